/* rtl/fcfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FCFS tick scheduler package
// Shared beat types, queue entry type and queue control type.
// ----------------------------------------------------------------------------
package fcfs_pkg;

  localparam logic [15:0] START_LIMIT_RESET = 16'd100;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  burst;
    logic [15:0] arrival;
  } entry_t;

  typedef struct packed {
    logic        arrival_valid;
    logic [7:0]  process_id;
    logic [7:0]  burst_length;
    logic [15:0] arrival_stamp;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] tick_index;
    logic        busy_res;
    logic [7:0]  running_id;
    logic        completed;
    logic [15:0] start_tick;
    logic [15:0] end_tick;
    logic [15:0] arrived_tick;
    logic        queue_full;
    logic        closed;
  } out_beat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

endpackage

/* rtl/fcfs_wait_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FCFS wait queue
// Circular buffer of waiting processes with a registered head entry.
// ----------------------------------------------------------------------------
module fcfs_wait_queue import fcfs_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  queue_ctrl_t                ctrl_i,
  input  entry_t                     push_entry_i,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output entry_t                     head_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  entry_t mem [DEPTH];

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW:0]   wr_sum;
  logic [AW-1:0] wr_addr;
  entry_t        rd_q;

  always_comb begin
    wr_sum = (AW + 1)'(head_q) + (AW + 1)'(count_q);
    if (wr_sum >= DEPTH_W) begin
      wr_sum = wr_sum - DEPTH_W;
    end
    wr_addr = wr_sum[AW-1:0];

    head_d = head_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
    end
    count_d = count_q + CW'(ctrl_i.push) - CW'(ctrl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_addr] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (wr_addr == head_d)) begin
      rd_q <= push_entry_i;
    end else begin
      rd_q <= mem[head_d];
    end
  end

  assign count_o = count_q;
  assign head_o  = rd_q;

endmodule

/* rtl/fcfs_tick_scheduler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FCFS tick scheduler core
// First-come-first-served scheduler that advances one tick per input beat until it closes.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    in_data_i (in_beat_t)
//   out      output     out_valid_o / out_ready_i  out_data_o (out_beat_t)
//   cfg      input      cfg_we_i                   cfg_wdata_i (start limit)
//
// Each accepted beat is one tick while open and yields one result beat in the next cycle.
// A new beat is taken every cycle while the result register is empty or drained.
// The queue head is held in a registered read of the queue memory.
// Reset clears all control state and loads the start limit with 100.
// A stalled output holds the result and blocks further input beats.
// ----------------------------------------------------------------------------
module fcfs_tick_scheduler_core import fcfs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic [15:0]   limit_q;
  logic          closed_q, closed_d;
  logic          running_q, running_d;
  entry_t        run_entry_q, run_entry_d;
  logic [7:0]    served_q, served_d;
  logic          started_q, started_d;
  logic [15:0]   first_q, first_d;
  logic [15:0]   tick_q, tick_d;
  logic          out_valid_q;
  out_beat_t     out_q, out_d;

  logic          accept;
  queue_ctrl_t   qctrl;
  logic [CW-1:0] q_count;
  entry_t        q_head;
  entry_t        in_entry;
  entry_t        cur_entry;
  logic          close_now;
  logic          full;
  logic          start;
  logic [7:0]    served_base;
  logic          started_base;
  logic [7:0]    served_n;
  logic          done;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign in_entry.id      = in_data_i.process_id;
  assign in_entry.burst   = in_data_i.burst_length;
  assign in_entry.arrival = in_data_i.arrival_stamp;

  fcfs_wait_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (qctrl),
    .push_entry_i(in_entry),
    .count_o     (q_count),
    .head_o      (q_head)
  );

  always_comb begin
    closed_d     = closed_q;
    running_d    = running_q;
    run_entry_d  = run_entry_q;
    served_d     = served_q;
    started_d    = started_q;
    first_d      = first_q;
    tick_d       = tick_q;
    out_d        = '0;
    qctrl        = '0;
    full         = 1'b0;
    start        = 1'b0;
    cur_entry    = run_entry_q;
    served_base  = served_q;
    started_base = started_q;
    served_n     = '0;
    done         = 1'b0;

    close_now = !closed_q && !running_q && (tick_q >= limit_q);
    out_d.tick_index = tick_q;

    if (closed_q || close_now) begin
      closed_d     = 1'b1;
      out_d.closed = 1'b1;
    end else begin
      if (in_data_i.arrival_valid) begin
        if (q_count >= DEPTH_C) begin
          full = 1'b1;
        end else begin
          qctrl.push = 1'b1;
        end
      end
      start = !running_q && (qctrl.push || (q_count != '0));
      if (start) begin
        qctrl.pop    = 1'b1;
        cur_entry    = (q_count == '0) ? in_entry : q_head;
        served_base  = '0;
        started_base = 1'b0;
      end
      if (running_q || start) begin
        out_d.busy_res   = 1'b1;
        out_d.running_id = cur_entry.id;
        first_d          = started_base ? first_q : tick_q;
        served_n         = served_base + 8'd1;
        done             = served_n >= cur_entry.burst;
        run_entry_d      = cur_entry;
        running_d        = !done;
        started_d        = !done;
        served_d         = done ? 8'd0 : served_n;
        if (done) begin
          out_d.completed    = 1'b1;
          out_d.start_tick   = first_d;
          out_d.end_tick     = tick_q;
          out_d.arrived_tick = cur_entry.arrival;
        end
      end
      out_d.queue_full = full;
      tick_d = tick_q + 16'd1;
    end

    if (!accept) begin
      qctrl = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= START_LIMIT_RESET;
      closed_q    <= 1'b0;
      running_q   <= 1'b0;
      run_entry_q <= '0;
      served_q    <= '0;
      started_q   <= 1'b0;
      first_q     <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        closed_q    <= closed_d;
        running_q   <= running_d;
        run_entry_q <= run_entry_d;
        served_q    <= served_d;
        started_q   <= started_d;
        first_q     <= first_d;
        tick_q      <= tick_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
